// ===== rtl/core/afw_pkg.sv =====
// Shared types, constants and the exponential lookup table for the fuzz waveshaper.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package afw_pkg;

	localparam int SMP_W = 16;
	localparam int GAIN_W = 16;
	localparam int V_W = 19;
	localparam int T_W = 24;
	localparam int XS_W = 15;
	localparam int P_W = T_W + XS_W;
	localparam int ACC_W = P_W + 1;

	localparam int ONE_Q14 = 16384;
	localparam int SAT_LIMIT = 131072;
	localparam int FUZZ_TOP = 15892;
	localparam int FUZZ_BOTTOM = -3785;
	localparam int NEG_08_Q15 = -26214;
	localparam int CUBA_LO = -4096;
	localparam int CUBB_LO = -8192;
	localparam int RND12 = 2048;
	localparam int RND14 = 8192;
	localparam int RND15 = 16384;
	localparam int RND20 = 524288;

	localparam logic signed [T_W-1:0] POLY_A0 = -24'sd402894;
	localparam logic signed [T_W-1:0] POLY_A1 = 24'sd623798;
	localparam logic signed [T_W-1:0] POLY_A2 = 24'sd827054;
	localparam logic signed [T_W-1:0] POLY_A3 = 24'sd0;
	localparam logic signed [T_W-1:0] POLY_B0 = 24'sd830818;
	localparam logic signed [T_W-1:0] POLY_B1 = 24'sd1549061;
	localparam logic signed [T_W-1:0] POLY_B2 = 24'sd1058328;
	localparam logic signed [T_W-1:0] POLY_B3 = 24'sd1928;

	localparam int EXP_TABLE_SIZE = 256;
	localparam int IDX_W = $clog2(EXP_TABLE_SIZE + 1);
	localparam int FRAC_W = 17;
	localparam int TAB_W = 31;
	localparam logic [63:0] EXP_STEP_H = (64'd8 << 32) / EXP_TABLE_SIZE;

	localparam int GAIN_STG = 2;
	localparam int SHAPE_STG = 4;
	localparam int PIPE_STG = 12;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FUZZ = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MORE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OCT = 8'd3;
	localparam logic [GAIN_W-1:0] GAIN_RST = 16'd2048;

	typedef logic [TAB_W-1:0] exp_tab_t [0:EXP_TABLE_SIZE];

	function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		logic [63:0] t;
		logic [63:0] r;
		logic [63:0] q;
		logic [63:0] nxt;
		t = 64'd1 << 32;
		r = t;
		for (int k = 1; k <= 16; k++) begin
			q = (t * EXP_STEP_H) >> 32;
			t = long_div(q, 64'(k));
			if (k % 2 == 1) begin
				r = r - t;
			end else begin
				r = r + t;
			end
		end
		tab[0] = TAB_W'(64'd1 << 30);
		for (int i = 1; i <= EXP_TABLE_SIZE; i++) begin
			nxt = (64'(tab[i-1]) * r + (64'd1 << 31)) >> 32;
			tab[i] = TAB_W'(nxt);
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

// ===== rtl/core/audio_fuzz_waveshaper.sv =====
// Top level of the fuzz waveshaper: stream ports, configuration registers, stage control.
// Instantiates afw_gain, afw_soft and two afw_fuzz; depends on afw_pkg.
`default_nettype none

// Signed Q2.14 samples go in and out on stream ports, one sample per clock sustained
// while the output is not back-pressured. A sample passes in order through gain and
// saturation, the first shaper (soft clip or fuzz, both four stages), the -0.8 rescale,
// the second fuzz pass (passed through unchanged unless fuzz mode with more drive),
// and the output register with half-wave rectification. Every stage has its own valid
// bit and moves whenever the stage after it is free, so bubbles close up under output
// back-pressure. Registers are written through the cfg channel, which is always ready;
// write them only while no sample is in flight.
module audio_fuzz_waveshaper (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [15:0]                       s_tdata,  // [15:0] sample_in
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata,  // [15:0] sample_out
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [afw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [afw_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import afw_pkg::*;

	localparam int PR_W = 32;

	logic [GAIN_W-1:0] gain_q;
	logic              fuzz_q;
	logic              more_q;
	logic              oct_q;

	logic [PIPE_STG:1] vld_q;
	logic [PIPE_STG:1] en;

	logic signed [SMP_W-1:0] sample;
	logic signed [V_W-1:0]   v_g;
	logic signed [SMP_W-1:0] y_soft;
	logic signed [SMP_W-1:0] y_fz1;
	logic signed [SMP_W-1:0] y_fz2;
	logic signed [SMP_W-1:0] sel_d;
	logic signed [SMP_W-1:0] pass_s7;
	logic signed [PR_W-1:0]  prod_s7;
	logic                    bypass;
	logic signed [V_W-1:0]   x2;
	logic [SMP_W-1:0]        out_s12;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RST;
			fuzz_q <= 1'b1;
			more_q <= 1'b0;
			oct_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GAIN: gain_q <= cfg_data;
				REG_FUZZ: fuzz_q <= cfg_data[0];
				REG_MORE: more_q <= cfg_data[0];
				REG_OCT:  oct_q <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		en[PIPE_STG] = !vld_q[PIPE_STG] || m_tready;
		for (int k = PIPE_STG - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	// advance valid bits with their stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= PIPE_STG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_q[PIPE_STG];
	assign sample = s_tdata;

	afw_gain u_gain (
		.clk    (clk),
		.en     (en[2:1]),
		.sample (sample),
		.gain   (gain_q),
		.v      (v_g)
	);

	afw_soft u_soft (
		.clk        (clk),
		.en         (en[6:3]),
		.more_drive (more_q),
		.v          (v_g),
		.y          (y_soft)
	);

	afw_fuzz u_fuzz1 (
		.clk    (clk),
		.en     (en[6:3]),
		.bypass (1'b0),
		.x      (v_g),
		.y      (y_fz1)
	);

	assign sel_d = fuzz_q ? y_fz1 : y_soft;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			pass_s7 <= sel_d;
			prod_s7 <= PR_W'(sel_d) * PR_W'(NEG_08_Q15);
		end
	end

	assign bypass = !(fuzz_q && more_q);
	assign x2 = bypass ? V_W'(pass_s7) : V_W'((prod_s7 + PR_W'(RND15)) >>> 15);

	afw_fuzz u_fuzz2 (
		.clk    (clk),
		.en     (en[11:8]),
		.bypass (bypass),
		.x      (x2),
		.y      (y_fz2)
	);

	// drop negative half in octave mode
	always_ff @(posedge clk) begin
		if (en[12]) begin
			out_s12 <= (oct_q && y_fz2[SMP_W-1]) ? '0 : y_fz2;
		end
	end

	assign m_tdata = out_s12;

endmodule

`default_nettype wire

// ===== rtl/core/afw_gain.sv =====
// Gain stage: signed sample times unsigned Q4.12 gain, rounded to Q14 and saturated to +/-8.
// Two pipeline stages; depends on afw_pkg.
`default_nettype none

module afw_gain (
	input  logic                                  clk,
	input  logic [afw_pkg::GAIN_STG:1]            en,
	input  logic signed [afw_pkg::SMP_W-1:0]      sample,
	input  logic [afw_pkg::GAIN_W-1:0]            gain,
	output logic signed [afw_pkg::V_W-1:0]        v
);
	import afw_pkg::*;

	localparam int M_W = SMP_W + GAIN_W + 1;

	logic signed [M_W-1:0] prod_d;
	logic signed [M_W-1:0] prod_s1;
	logic signed [M_W-1:0] sh_d;
	logic signed [V_W-1:0] v_d;
	logic signed [V_W-1:0] v_s2;

	assign prod_d = M_W'(sample) * M_W'($signed({1'b0, gain}));
	assign sh_d = (prod_s1 + M_W'(RND12)) >>> 12;

	always_comb begin
		if (sh_d > M_W'(SAT_LIMIT)) begin
			v_d = V_W'(SAT_LIMIT);
		end else if (sh_d < -M_W'(SAT_LIMIT)) begin
			v_d = -V_W'(SAT_LIMIT);
		end else begin
			v_d = V_W'(sh_d);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s1 <= prod_d;
		end
		if (en[2]) begin
			v_s2 <= v_d;
		end
	end

	assign v = v_s2;

endmodule

`default_nettype wire

// ===== rtl/core/afw_soft.sv =====
// Exponential soft clip: 2*(1-exp(-|x|)) by interpolated table, hard limit, sign restored.
// Four pipeline stages; depends on afw_pkg for the table and widths.
`default_nettype none

module afw_soft (
	input  logic                                  clk,
	input  logic [afw_pkg::SHAPE_STG:1]           en,
	input  logic                                  more_drive,
	input  logic signed [afw_pkg::V_W-1:0]        v,
	output logic signed [afw_pkg::SMP_W-1:0]      y
);
	import afw_pkg::*;

	localparam int A_W = V_W - 1;
	localparam int SP_W = FRAC_W + IDX_W;
	localparam int MUL_W = TAB_W + FRAC_W;
	localparam int NUM_W = 32;
	localparam int Y_W = NUM_W - 15;

	logic [A_W-1:0]    mag_d;
	logic [SP_W-1:0]   pos_d;
	logic [IDX_W-1:0]  idx_s1;
	logic [FRAC_W-1:0] frac_s1;
	logic              neg_s1;

	logic [IDX_W-1:0]  hi_d;
	logic [TAB_W-1:0]  tab_s2;
	logic [TAB_W-1:0]  dif_s2;
	logic [FRAC_W-1:0] frac_s2;
	logic              neg_s2;

	logic [MUL_W-1:0]  m_s3;
	logic [TAB_W-1:0]  tab_s3;
	logic              neg_s3;

	logic [TAB_W-1:0]  e_d;
	logic [NUM_W-1:0]  num_d;
	logic [Y_W-1:0]    yraw_d;
	logic [Y_W-1:0]    lim_d;
	logic [Y_W-1:0]    ymag_d;
	logic signed [SMP_W-1:0] y_s4;

	assign mag_d = v[V_W-1] ? A_W'(-v) : A_W'(v);
	assign pos_d = SP_W'(mag_d) * SP_W'(EXP_TABLE_SIZE);
	assign hi_d = (idx_s1 == IDX_W'(EXP_TABLE_SIZE)) ? idx_s1 : idx_s1 + IDX_W'(1);

	assign e_d = tab_s3 - TAB_W'(m_s3 >> FRAC_W);
	assign num_d = NUM_W'(64'd1 << 30) - NUM_W'(e_d) + NUM_W'(ONE_Q14);
	assign yraw_d = num_d[NUM_W-1:15];
	assign lim_d = more_drive ? Y_W'(ONE_Q14 / 2) : Y_W'(ONE_Q14);
	assign ymag_d = (yraw_d > lim_d) ? lim_d : yraw_d;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			idx_s1 <= pos_d[FRAC_W +: IDX_W];
			frac_s1 <= pos_d[FRAC_W-1:0];
			neg_s1 <= v[V_W-1];
		end
		if (en[2]) begin
			tab_s2 <= EXP_TAB[idx_s1];
			dif_s2 <= EXP_TAB[idx_s1] - EXP_TAB[hi_d];
			frac_s2 <= frac_s1;
			neg_s2 <= neg_s1;
		end
		if (en[3]) begin
			m_s3 <= MUL_W'(dif_s2) * MUL_W'(frac_s2);
			tab_s3 <= tab_s2;
			neg_s3 <= neg_s2;
		end
		if (en[4]) begin
			y_s4 <= neg_s3 ? -SMP_W'(ymag_d) : SMP_W'(ymag_d);
		end
	end

	assign y = y_s4;

endmodule

`default_nettype wire

// ===== rtl/core/afw_fuzz.sv =====
// Piecewise fuzz shaper: top and bottom plateaus, identity, two Horner cubics.
// Four pipeline stages, one multiply in each stage but the last; depends on afw_pkg.
`default_nettype none

module afw_fuzz (
	input  logic                                  clk,
	input  logic [afw_pkg::SHAPE_STG:1]           en,
	input  logic                                  bypass,
	input  logic signed [afw_pkg::V_W-1:0]        x,
	output logic signed [afw_pkg::SMP_W-1:0]      y
);
	import afw_pkg::*;

	typedef enum logic [2:0] {
		RG_TOP  = 3'd0,
		RG_LIN  = 3'd1,
		RG_CUBA = 3'd2,
		RG_CUBB = 3'd3,
		RG_BOT  = 3'd4
	} fz_region_t;

	fz_region_t            region_d;
	logic                  selb_d;
	logic signed [XS_W-1:0] xs_d;
	logic signed [T_W-1:0] c0_d;
	logic signed [P_W-1:0] prod1_d;

	fz_region_t            region_s1, region_s2, region_s3;
	logic                  selb_s1, selb_s2, selb_s3;
	logic signed [XS_W-1:0] xs_s1, xs_s2;
	logic [SMP_W-1:0]      lin_s1, lin_s2, lin_s3;
	logic signed [P_W-1:0] prod1_s1, prod2_s2, prod3_s3;

	logic signed [T_W-1:0] t1_d, t2_d;
	logic signed [P_W-1:0] prod2_d, prod3_d;
	logic signed [T_W-1:0] c3_d;
	logic signed [ACC_W-1:0] acc_d;
	logic signed [SMP_W-1:0] y_d;
	logic signed [SMP_W-1:0] y_s4;

	always_comb begin
		if (bypass) begin
			region_d = RG_LIN;
		end else if (x >= V_W'(ONE_Q14)) begin
			region_d = RG_TOP;
		end else if (x >= V_W'(0)) begin
			region_d = RG_LIN;
		end else if (x >= V_W'(CUBA_LO)) begin
			region_d = RG_CUBA;
		end else if (x >= V_W'(CUBB_LO)) begin
			region_d = RG_CUBB;
		end else begin
			region_d = RG_BOT;
		end
	end

	assign selb_d = (x < V_W'(CUBA_LO));
	assign xs_d = x[XS_W-1:0];
	assign c0_d = selb_d ? POLY_B0 : POLY_A0;
	assign prod1_d = P_W'(c0_d) * P_W'(xs_d);

	assign t1_d = (selb_s1 ? POLY_B1 : POLY_A1) + T_W'((prod1_s1 + P_W'(RND14)) >>> 14);
	assign prod2_d = P_W'(t1_d) * P_W'(xs_s1);
	assign t2_d = (selb_s2 ? POLY_B2 : POLY_A2) + T_W'((prod2_s2 + P_W'(RND14)) >>> 14);
	assign prod3_d = P_W'(t2_d) * P_W'(xs_s2);

	assign c3_d = selb_s3 ? POLY_B3 : POLY_A3;
	assign acc_d = (ACC_W'(prod3_s3) + (ACC_W'(c3_d) <<< 14) + ACC_W'(RND20)) >>> 20;

	always_comb begin
		case (region_s3)
			RG_TOP:  y_d = SMP_W'(FUZZ_TOP);
			RG_LIN:  y_d = lin_s3;
			RG_CUBA: y_d = SMP_W'(acc_d);
			RG_CUBB: y_d = SMP_W'(acc_d);
			RG_BOT:  y_d = SMP_W'(FUZZ_BOTTOM);
			default: y_d = SMP_W'(FUZZ_BOTTOM);
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			region_s1 <= region_d;
			selb_s1 <= selb_d;
			xs_s1 <= xs_d;
			lin_s1 <= x[SMP_W-1:0];
			prod1_s1 <= prod1_d;
		end
		if (en[2]) begin
			region_s2 <= region_s1;
			selb_s2 <= selb_s1;
			xs_s2 <= xs_s1;
			lin_s2 <= lin_s1;
			prod2_s2 <= prod2_d;
		end
		if (en[3]) begin
			region_s3 <= region_s2;
			selb_s3 <= selb_s2;
			lin_s3 <= lin_s2;
			prod3_s3 <= prod3_d;
		end
		if (en[4]) begin
			y_s4 <= y_d;
		end
	end

	assign y = y_s4;

endmodule

`default_nettype wire
